### design/yaw_pitch_view_basis_assert.svh
// Assertion macros for the yaw/pitch view basis block.
// Used by design/yaw_pitch_view_basis.sv; needs a clock i_clk and reset i_rst_n in scope.
`ifndef YAW_PITCH_VIEW_BASIS_ASSERT_SVH
`define YAW_PITCH_VIEW_BASIS_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define YPVB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define YPVB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ypvb_pkg.sv
// Package for the yaw/pitch view basis block: angle constants, CORDIC table,
// sequencer states and rounding/saturation helpers. No dependencies.
package ypvb_pkg;

    // CORDIC step count, capped by the arctangent table length
    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_STEPS      = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_STEPS) ?
                                     TRIG_ITERATIONS : ATAN_STEPS;
    localparam int IT_W            = $clog2(ATAN_STEPS);

    // Angles in Q9.16 degrees
    localparam int DEG90     = 5898240;
    localparam int DEG180    = 11796480;
    localparam int DEG360    = 23592960;
    localparam int PITCH_LIM = 5832704;

    // Wrap reduction works on a 33-bit value, subtracting 360 << k for k = top..0
    localparam int WRAP_W   = 33;
    localparam int WRAP_TOP = 5;
    localparam int WRAP_K_W = 3;

    // CORDIC datapath widths: x/y in Q2.30, residue in Q.16 degrees
    localparam int XY_W = 32;
    localparam int Z_W  = 25;
    localparam int CORDIC_INV_GAIN = 652032874;

    localparam int ONE14 = 16384;
    localparam int PROD_LAST = 4;

    // atan(2^-i) in Q.16 degrees
    localparam logic signed [Z_W-1:0] ATAN_TABLE [ATAN_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_PITCH,
        ST_WRAP_PREP,
        ST_WRAP,
        ST_FOLD,
        ST_CORDIC_YAW,
        ST_CORDIC_PITCH,
        ST_PROD,
        ST_OUT
    } t_state;

    // Saturate to plus or minus one in Q1.14
    function automatic logic signed [15:0] sat14(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd16384) begin
            r = 16'sd16384;
        end else if (v < -18'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // Q2.30 to Q1.14, round half up
    function automatic logic signed [15:0] to14(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] s;
        s = (XY_W+1)'(v) + (XY_W+1)'(33'sd32768);
        return sat14(18'($signed(s[XY_W:16])));
    endfunction

    // Q4.60 product to Q1.14, round half up
    function automatic logic signed [15:0] mul14(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sh0000_2000_0000_0000;
        return sat14(s[63:46]);
    endfunction

    // Clamp pitch to plus or minus 89 degrees
    function automatic logic signed [23:0] clamp_pitch(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'(PITCH_LIM)) begin
            r = 24'(PITCH_LIM);
        end else if (v < -32'(PITCH_LIM)) begin
            r = -24'(PITCH_LIM);
        end else begin
            r = 24'(v);
        end
        return r;
    endfunction

    // 360 degrees shifted left by k
    function automatic logic signed [WRAP_W-1:0] wrap_step(input logic [WRAP_K_W-1:0] k);
        logic signed [WRAP_W-1:0] b;
        b = WRAP_W'(DEG360);
        return b <<< k;
    endfunction

endpackage

### design/yaw_pitch_view_basis.sv
// Yaw/pitch camera orientation unit with view basis output.
// Depends on design/ypvb_pkg.sv and design/yaw_pitch_view_basis_assert.svh.
//
// Usage:
//   Input channel (i_valid / o_stall): one request is either a move (i_action 0,
//   pointer offsets scaled by the sensitivity register) or a set (i_action 1,
//   angles loaded directly). A request is taken when i_valid is high and o_stall
//   is low. o_stall stays high from acceptance until the result is taken.
//   Output channel (o_valid / i_stall): one result per request carries the
//   wrapped yaw, clamped pitch and the eight basis terms. The result holds
//   while i_stall is high; the next request is taken once it leaves.
//   Configuration (i_cfg_valid / o_cfg_ready): writes the sensitivity; ready is
//   always high. Write only while no request is in flight.
// Sequence: a move scales both offsets and clamps pitch, then both kinds wrap
//   yaw in 6 compare/subtract steps, the shared CORDIC step unit runs for yaw
//   and then for pitch, and one shared 32x32 multiplier does the two offset
//   scalings and the four basis products.
// A new request is taken only once the result has been taken and the block is
//   idle again, so each stalled result cycle delays the next request.
// Reset (synchronous, active low): yaw and pitch return to zero, sensitivity
//   to 6554 (0.1), and the block comes up idle with no result pending.
`include "yaw_pitch_view_basis_assert.svh"

module yaw_pitch_view_basis (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  logic signed [15:0]  i_x_offset,
    input  logic signed [15:0]  i_y_offset,
    input  logic signed [24:0]  i_new_yaw,
    input  logic signed [23:0]  i_new_pitch,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [24:0]  o_yaw_out,
    output logic signed [23:0]  o_pitch_out,
    output logic signed [15:0]  o_dir_x,
    output logic signed [15:0]  o_dir_y,
    output logic signed [15:0]  o_dir_z,
    output logic signed [15:0]  o_right_x,
    output logic signed [15:0]  o_right_z,
    output logic signed [15:0]  o_up_x,
    output logic signed [15:0]  o_up_y,
    output logic signed [15:0]  o_up_z,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [17:0]         i_cfg_sensitivity
);

    localparam int XY_W = ypvb_pkg::XY_W;
    localparam int Z_W  = ypvb_pkg::Z_W;
    localparam int W_W  = ypvb_pkg::WRAP_W;

    ypvb_pkg::t_state r_state, n_state;

    logic [17:0]                       r_sens;
    logic signed [24:0]                r_yaw;
    logic signed [23:0]                r_pitch;
    logic signed [15:0]                r_x_off, r_y_off;
    logic signed [W_W-1:0]             r_wrap;
    logic [ypvb_pkg::WRAP_K_W-1:0]     r_k;
    logic                              r_fold;
    logic signed [XY_W-1:0]            r_cx, r_cy;
    logic signed [Z_W-1:0]             r_z;
    logic [ypvb_pkg::IT_W-1:0]         r_it;
    logic signed [XY_W-1:0]            r_cos_y, r_sin_y, r_cos_p, r_sin_p;
    logic signed [63:0]                r_prod;
    logic [2:0]                        r_cnt;
    logic signed [15:0]                r_dir_x, r_dir_y, r_dir_z;
    logic signed [15:0]                r_right_x, r_right_z;
    logic signed [15:0]                r_up_x, r_up_y, r_up_z;

    logic                              in_acc;
    logic                              it_last;
    logic signed [XY_W-1:0]            mul_a, mul_b;
    logic signed [33:0]                off_rnd;
    logic signed [29:0]                off_scaled;
    logic signed [W_W-1:0]             yaw_sum;
    logic signed [31:0]                pitch_sum;
    logic signed [24:0]                yaw_w;
    logic signed [XY_W-1:0]            dx, dy, nx, ny;
    logic signed [Z_W-1:0]             nz;

    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != ypvb_pkg::ST_IDLE);
    assign o_valid     = (r_state == ypvb_pkg::ST_OUT);
    assign o_cfg_ready = 1'b1;
    assign it_last     = (r_it == ypvb_pkg::IT_W'(ypvb_pkg::CORDIC_STEPS - 1));

    // Offset scaling: round Q13.20 product to Q.16 (half up)
    assign off_rnd    = $signed(r_prod[33:0]) + 34'sd8;
    assign off_scaled = off_rnd[33:4];
    assign yaw_sum    = W_W'(r_yaw) + W_W'(off_scaled) + W_W'(ypvb_pkg::DEG180);
    assign pitch_sum  = 32'(r_pitch) + 32'(off_scaled);
    assign yaw_w      = 25'(r_wrap - W_W'(ypvb_pkg::DEG180));

    // Shared CORDIC rotation step
    always_comb begin
        dx = r_cy >>> r_it;
        dy = r_cx >>> r_it;
        if (!r_z[Z_W-1]) begin
            nx = r_cx - dx;
            ny = r_cy + dy;
            nz = r_z - ypvb_pkg::ATAN_TABLE[r_it];
        end else begin
            nx = r_cx + dx;
            ny = r_cy - dy;
            nz = r_z + ypvb_pkg::ATAN_TABLE[r_it];
        end
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ypvb_pkg::ST_MUL_X: begin
                mul_a = XY_W'(r_x_off);
                mul_b = $signed(XY_W'(r_sens));
            end
            ypvb_pkg::ST_MUL_Y: begin
                mul_a = XY_W'(r_y_off);
                mul_b = $signed(XY_W'(r_sens));
            end
            ypvb_pkg::ST_PROD: begin
                case (r_cnt)
                    3'd0: begin
                        mul_a = r_cos_y;
                        mul_b = r_cos_p;
                    end
                    3'd1: begin
                        mul_a = r_sin_y;
                        mul_b = r_cos_p;
                    end
                    3'd2: begin
                        mul_a = -r_cos_y;
                        mul_b = r_sin_p;
                    end
                    3'd3: begin
                        mul_a = -r_sin_y;
                        mul_b = r_sin_p;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ypvb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ypvb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_action ? ypvb_pkg::ST_WRAP_PREP : ypvb_pkg::ST_MUL_X;
                end
            end
            ypvb_pkg::ST_MUL_X:     n_state = ypvb_pkg::ST_MUL_Y;
            ypvb_pkg::ST_MUL_Y:     n_state = ypvb_pkg::ST_PITCH;
            ypvb_pkg::ST_PITCH:     n_state = ypvb_pkg::ST_WRAP_PREP;
            ypvb_pkg::ST_WRAP_PREP: n_state = ypvb_pkg::ST_WRAP;
            ypvb_pkg::ST_WRAP: begin
                if (r_k == '0) begin
                    n_state = ypvb_pkg::ST_FOLD;
                end
            end
            ypvb_pkg::ST_FOLD:      n_state = ypvb_pkg::ST_CORDIC_YAW;
            ypvb_pkg::ST_CORDIC_YAW: begin
                if (it_last) begin
                    n_state = ypvb_pkg::ST_CORDIC_PITCH;
                end
            end
            ypvb_pkg::ST_CORDIC_PITCH: begin
                if (it_last) begin
                    n_state = ypvb_pkg::ST_PROD;
                end
            end
            ypvb_pkg::ST_PROD: begin
                if (r_cnt == 3'(ypvb_pkg::PROD_LAST)) begin
                    n_state = ypvb_pkg::ST_OUT;
                end
            end
            ypvb_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = ypvb_pkg::ST_IDLE;
                end
            end
            default: n_state = ypvb_pkg::ST_IDLE;
        endcase
    end

    // Sensitivity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= 18'd6554;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sens <= i_cfg_sensitivity;
        end
    end

    // Angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= '0;
            r_pitch <= '0;
        end else begin
            if (r_state == ypvb_pkg::ST_IDLE && in_acc && i_action) begin
                r_pitch <= ypvb_pkg::clamp_pitch(32'(i_new_pitch));
            end else if (r_state == ypvb_pkg::ST_PITCH) begin
                r_pitch <= ypvb_pkg::clamp_pitch(pitch_sum);
            end
            if (r_state == ypvb_pkg::ST_FOLD) begin
                r_yaw <= yaw_w;
            end
        end
    end

    // Datapath: multiplier, wrap reduction, CORDIC, basis products
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ypvb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_x_off <= i_x_offset;
                    r_y_off <= i_y_offset;
                    r_wrap  <= W_W'(i_new_yaw) + W_W'(ypvb_pkg::DEG180);
                end
            end
            ypvb_pkg::ST_MUL_Y: begin
                r_wrap <= yaw_sum;
            end
            ypvb_pkg::ST_WRAP_PREP: begin
                // lift negative values so the binary reduction sees [0, 64*360)
                if (r_wrap[W_W-1]) begin
                    r_wrap <= r_wrap + ypvb_pkg::wrap_step(
                                  ypvb_pkg::WRAP_K_W'(ypvb_pkg::WRAP_TOP));
                end
                r_k <= ypvb_pkg::WRAP_K_W'(ypvb_pkg::WRAP_TOP);
            end
            ypvb_pkg::ST_WRAP: begin
                if (r_wrap >= ypvb_pkg::wrap_step(r_k)) begin
                    r_wrap <= r_wrap - ypvb_pkg::wrap_step(r_k);
                end
                r_k <= r_k - 1'b1;
            end
            ypvb_pkg::ST_FOLD: begin
                // yaw outside plus or minus 90: rotate by 180, negate results
                if (yaw_w > 25'(ypvb_pkg::DEG90)) begin
                    r_z    <= yaw_w - 25'(ypvb_pkg::DEG180);
                    r_fold <= 1'b1;
                end else if (yaw_w < -25'(ypvb_pkg::DEG90)) begin
                    r_z    <= yaw_w + 25'(ypvb_pkg::DEG180);
                    r_fold <= 1'b1;
                end else begin
                    r_z    <= yaw_w;
                    r_fold <= 1'b0;
                end
                r_cx <= XY_W'(ypvb_pkg::CORDIC_INV_GAIN);
                r_cy <= '0;
                r_it <= '0;
            end
            ypvb_pkg::ST_CORDIC_YAW: begin
                if (it_last) begin
                    r_cos_y <= r_fold ? -nx : nx;
                    r_sin_y <= r_fold ? -ny : ny;
                    r_cx    <= XY_W'(ypvb_pkg::CORDIC_INV_GAIN);
                    r_cy    <= '0;
                    r_z     <= Z_W'(r_pitch);
                    r_it    <= '0;
                end else begin
                    r_cx <= nx;
                    r_cy <= ny;
                    r_z  <= nz;
                    r_it <= r_it + 1'b1;
                end
            end
            ypvb_pkg::ST_CORDIC_PITCH: begin
                if (it_last) begin
                    r_cos_p <= nx;
                    r_sin_p <= ny;
                    r_cnt   <= '0;
                end else begin
                    r_cx <= nx;
                    r_cy <= ny;
                    r_z  <= nz;
                    r_it <= r_it + 1'b1;
                end
            end
            ypvb_pkg::ST_PROD: begin
                // product issued at count c is registered in r_prod and read at count c + 1
                r_cnt <= r_cnt + 1'b1;
                case (r_cnt)
                    3'd1: r_dir_x <= ypvb_pkg::mul14(r_prod);
                    3'd2: r_dir_z <= ypvb_pkg::mul14(r_prod);
                    3'd3: r_up_x  <= ypvb_pkg::mul14(r_prod);
                    3'd4: begin
                        r_up_z    <= ypvb_pkg::mul14(r_prod);
                        r_dir_y   <= ypvb_pkg::to14(r_sin_p);
                        r_right_x <= ypvb_pkg::to14(-r_sin_y);
                        r_right_z <= ypvb_pkg::to14(r_cos_y);
                        r_up_y    <= ypvb_pkg::to14(r_cos_p);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_yaw_out   = r_yaw;
    assign o_pitch_out = r_pitch;
    assign o_dir_x     = r_dir_x;
    assign o_dir_y     = r_dir_y;
    assign o_dir_z     = r_dir_z;
    assign o_right_x   = r_right_x;
    assign o_right_z   = r_right_z;
    assign o_up_x      = r_up_x;
    assign o_up_y      = r_up_y;
    assign o_up_z      = r_up_z;

    // Checks
    `YPVB_ASSERT_NOW(a_result_blocks_input, o_valid, o_stall, "result pending but input open")
    `YPVB_ASSERT_NEXT(a_accept_goes_busy, in_acc, o_stall, "accepted request left block idle")
    `YPVB_ASSERT_NOW(a_pitch_in_range, 1'b1, (r_pitch <= 24'(ypvb_pkg::PITCH_LIM)) && (r_pitch >= -24'(ypvb_pkg::PITCH_LIM)), "pitch outside clamp")
    `YPVB_ASSERT_NOW(a_yaw_in_range, 1'b1, (r_yaw <= 25'(ypvb_pkg::DEG180 - 1)) && (r_yaw >= -25'(ypvb_pkg::DEG180)), "yaw outside wrap range")

endmodule

### verif/tb_yaw_pitch_view_basis.sv
`timescale 1ns / 1ps
// Self-checking testbench for yaw_pitch_view_basis: move and set requests with random
// handshake pacing, checked against an in-bench camera predictor (CORDIC in longint).
// Depends on design/ypvb_pkg.sv and design/yaw_pitch_view_basis.sv.

module tb_yaw_pitch_view_basis;

    // Request opcodes
    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    // Angles in Q9.16 degrees
    localparam longint ANG_90    = 5898240;
    localparam longint ANG_180   = 11796480;
    localparam longint ANG_360   = 23592960;
    localparam longint PITCH_MAX = 5832704;
    localparam longint UNIT_Q14  = 16384;
    localparam longint CORDIC_K  = 652032874;
    localparam int     TRIG_STEPS = (ypvb_pkg::TRIG_ITERATIONS < 24) ?
                                    ypvb_pkg::TRIG_ITERATIONS : 24;
    localparam logic [17:0] SENS_RESET = 18'd6554;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEMS_PER_PHASE = 47;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HOLD} t_stall_mode;

    typedef struct {
        logic               action;
        logic signed [15:0] x_off;
        logic signed [15:0] y_off;
        logic signed [24:0] yaw_in;
        logic signed [23:0] pitch_in;
    } t_cam_req;

    typedef struct {
        logic signed [24:0] yaw;
        logic signed [23:0] pitch;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_view_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_action = ACT_MOVE;
    logic signed [15:0] i_x_offset = '0;
    logic signed [15:0] i_y_offset = '0;
    logic signed [24:0] i_new_yaw = '0;
    logic signed [23:0] i_new_pitch = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [24:0] o_yaw_out;
    logic signed [23:0] o_pitch_out;
    logic signed [15:0] o_dir_x;
    logic signed [15:0] o_dir_y;
    logic signed [15:0] o_dir_z;
    logic signed [15:0] o_right_x;
    logic signed [15:0] o_right_z;
    logic signed [15:0] o_up_x;
    logic signed [15:0] o_up_y;
    logic signed [15:0] o_up_z;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [17:0]        i_cfg_sensitivity = SENS_RESET;

    yaw_pitch_view_basis uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_x_offset        (i_x_offset),
        .i_y_offset        (i_y_offset),
        .i_new_yaw         (i_new_yaw),
        .i_new_pitch       (i_new_pitch),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_yaw_out         (o_yaw_out),
        .o_pitch_out       (o_pitch_out),
        .o_dir_x           (o_dir_x),
        .o_dir_y           (o_dir_y),
        .o_dir_z           (o_dir_z),
        .o_right_x         (o_right_x),
        .o_right_z         (o_right_z),
        .o_up_x            (o_up_x),
        .o_up_y            (o_up_y),
        .o_up_z            (o_up_z),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_sensitivity (i_cfg_sensitivity)
    );

    always #2 i_clk = ~i_clk;

    // Camera state mirrored by the predictor
    longint cam_yaw = 0;
    longint cam_pitch = 0;
    longint cam_sens = SENS_RESET;

    t_cam_req  req_backlog[$];
    t_view_res view_expect[$];

    int     n_mismatch = 0;
    int     n_checked = 0;
    int     n_moves = 0;
    int     n_sets = 0;
    int     n_settings = 0;
    int     cycles = 0;
    int     pitch_drift = 1;
    logic   req_took = 1'b0;
    int     gap_left = 0;
    int     burst_left = 1;
    t_cam_req cur_req;
    t_stall_mode stall_mode = STALL_NONE;
    int     stall_timer = 0;
    int     stall_run = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint atan_step(int i);
        case (i)
            0: return 2949120;   1: return 1740967;   2: return 919879;    3: return 466945;
            4: return 234379;    5: return 117304;    6: return 58666;     7: return 29335;
            8: return 14668;     9: return 7334;      10: return 3667;     11: return 1833;
            12: return 917;      13: return 458;      14: return 229;      15: return 115;
            16: return 57;       17: return 29;       18: return 14;       19: return 7;
            20: return 4;        21: return 2;        22: return 1;
            default: return 0;
        endcase
    endfunction

    // Rotation-mode CORDIC, Q2.30 out, angle in Q.16 degrees
    function automatic void cordic_rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = CORDIC_K;
        y = 0;
        z = ang;
        for (int i = 0; i < TRIG_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint sat_unit(longint v);
        if (v > UNIT_Q14) return UNIT_Q14;
        if (v < -UNIT_Q14) return -UNIT_Q14;
        return v;
    endfunction

    function automatic longint q30_to_q14(longint v);
        return sat_unit((v + (longint'(1) <<< 15)) >>> 16);
    endfunction

    function automatic longint mul_to_q14(longint a, longint b);
        return sat_unit((a * b + (longint'(1) <<< 45)) >>> 46);
    endfunction

    // Offset times sensitivity, Q.20 rounded half up to Q.16
    function automatic longint scale_offset(longint off);
        return (off * cam_sens + 8) >>> 4;
    endfunction

    function automatic longint wrap_yaw_deg(longint v);
        longint r;
        r = (v + ANG_180) % ANG_360;
        if (r < 0) r = r + ANG_360;
        return r - ANG_180;
    endfunction

    function automatic longint clamp_pitch_deg(longint v);
        if (v > PITCH_MAX) return PITCH_MAX;
        if (v < -PITCH_MAX) return -PITCH_MAX;
        return v;
    endfunction

    // Update the camera with one request and return the expected view
    function automatic t_view_res advance_camera(t_cam_req r);
        longint cy, sy, cp, sp;
        t_view_res v;
        if (r.action == ACT_MOVE) begin
            cam_yaw = wrap_yaw_deg(cam_yaw + scale_offset(longint'(r.x_off)));
            cam_pitch = clamp_pitch_deg(cam_pitch + scale_offset(longint'(r.y_off)));
        end else begin
            cam_yaw = wrap_yaw_deg(longint'(r.yaw_in));
            cam_pitch = clamp_pitch_deg(longint'(r.pitch_in));
        end
        // fold yaw into plus or minus 90 degrees, negate both terms
        if (cam_yaw > ANG_90) begin
            cordic_rotate(cam_yaw - ANG_180, cy, sy);
            cy = -cy;
            sy = -sy;
        end else if (cam_yaw < -ANG_90) begin
            cordic_rotate(cam_yaw + ANG_180, cy, sy);
            cy = -cy;
            sy = -sy;
        end else begin
            cordic_rotate(cam_yaw, cy, sy);
        end
        cordic_rotate(cam_pitch, cp, sp);
        v.yaw     = 25'(cam_yaw);
        v.pitch   = 24'(cam_pitch);
        v.dir_x   = 16'(mul_to_q14(cy, cp));
        v.dir_y   = 16'(q30_to_q14(sp));
        v.dir_z   = 16'(mul_to_q14(sy, cp));
        v.right_x = 16'(q30_to_q14(-sy));
        v.right_z = 16'(q30_to_q14(cy));
        v.up_x    = 16'(mul_to_q14(-cy, sp));
        v.up_y    = 16'(q30_to_q14(cp));
        v.up_z    = 16'(mul_to_q14(-sy, sp));
        return v;
    endfunction

    function automatic void check_field(string tag, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            n_mismatch++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, junk payload while idle
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_took) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                i_valid     <= 1'b0;
                i_action    <= 1'($urandom);
                i_x_offset  <= 16'($urandom);
                i_y_offset  <= 16'($urandom);
                i_new_yaw   <= 25'($urandom);
                i_new_pitch <= 24'($urandom);
            end else if (req_backlog.size() > 0) begin
                cur_req = req_backlog.pop_front();
                i_valid     <= 1'b1;
                i_action    <= cur_req.action;
                i_x_offset  <= cur_req.x_off;
                i_y_offset  <= cur_req.y_off;
                i_new_yaw   <= cur_req.yaw_in;
                i_new_pitch <= cur_req.pitch_in;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                              : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result-side stall: mode picked at random among none, coin flip and held runs
    always @(negedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  <= t_stall_mode'($urandom_range(0, 2));
            stall_timer <= $urandom_range(40, 200);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_COIN: begin
                i_stall <= 1'($urandom);
            end
            default: begin
                if (stall_run > 0) begin
                    i_stall   <= 1'b1;
                    stall_run <= stall_run - 1;
                end else begin
                    i_stall <= 1'b0;
                    if ($urandom_range(0, 7) == 0) stall_run <= $urandom_range(1, 24);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict on request accept, compare on result accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_view_res want;
        t_cam_req  taken;
        if (!i_rst_n) begin
            req_took <= 1'b0;
        end else begin
            req_took <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (view_expect.size() == 0) begin
                    $display("%0t: result with no request pending, yaw %0d pitch %0d",
                             $time, o_yaw_out, o_pitch_out);
                    n_mismatch++;
                end else begin
                    want = view_expect.pop_front();
                    check_field("yaw_out", want.yaw, o_yaw_out);
                    check_field("pitch_out", want.pitch, o_pitch_out);
                    check_field("dir_x", want.dir_x, o_dir_x);
                    check_field("dir_y", want.dir_y, o_dir_y);
                    check_field("dir_z", want.dir_z, o_dir_z);
                    check_field("right_x", want.right_x, o_right_x);
                    check_field("right_z", want.right_z, o_right_z);
                    check_field("up_x", want.up_x, o_up_x);
                    check_field("up_y", want.up_y, o_up_y);
                    check_field("up_z", want.up_z, o_up_z);
                    n_checked++;
                end
            end
            if (i_valid && !o_stall) begin
                taken.action   = i_action;
                taken.x_off    = i_x_offset;
                taken.y_off    = i_y_offset;
                taken.yaw_in   = i_new_yaw;
                taken.pitch_in = i_new_pitch;
                if (i_action == ACT_MOVE) n_moves++;
                else n_sets++;
                view_expect.push_back(advance_camera(taken));
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d views outstanding", cycles,
                     view_expect.size());
            $display("yaw_pitch_view_basis test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_request(input logic act, input int xo, input int yo,
                                 input int ny, input int np);
        t_cam_req r;
        r.action   = act;
        r.x_off    = 16'(xo);
        r.y_off    = 16'(yo);
        r.yaw_in   = 25'(ny);
        r.pitch_in = 24'(np);
        req_backlog.push_back(r);
    endtask

    // Mostly small drifting moves, plus full-range moves and sets
    task automatic queue_random_requests(input int count);
        int pick, xo, yo;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0) pitch_drift = -pitch_drift;
            if (pick < 55) begin
                xo = int'($urandom_range(0, 4000)) - 2000;
                yo = pitch_drift * int'($urandom_range(0, 1500)) +
                     int'($urandom_range(0, 200)) - 100;
                queue_request(ACT_MOVE, xo, yo, int'($urandom), int'($urandom));
            end else if (pick < 72) begin
                queue_request(ACT_MOVE, int'($urandom), int'($urandom),
                              int'($urandom), int'($urandom));
            end else if (pick < 90) begin
                queue_request(ACT_SET, int'($urandom), int'($urandom),
                              int'($urandom_range(0, 23592959)) - 11796480,
                              int'($urandom_range(0, 11665408)) - 5832704);
            end else begin
                queue_request(ACT_SET, int'($urandom), int'($urandom),
                              int'($urandom), int'($urandom));
            end
        end
    endtask

    // Sender holds off until every view has come back
    task automatic wait_for_views();
        while (req_backlog.size() != 0 || i_valid || view_expect.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_sensitivity(input logic [17:0] v);
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_sensitivity <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cam_sens = v;
        n_settings++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [17:0] sens_plan [7];
        sens_plan = '{18'd0, 18'h3FFFF, 18'd1, SENS_RESET, 18'd65536, 18'h0, 18'h0};
        sens_plan[5] = 18'($urandom);
        sens_plan[6] = 18'($urandom_range(1000, 20000));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: angle extremes, wrap and fold points, saturation, offset extremes
        queue_request(ACT_SET, int'($urandom), int'($urandom), 0, 0);
        queue_request(ACT_SET, int'($urandom), int'($urandom), 11796479, 5832704);
        queue_request(ACT_SET, int'($urandom), int'($urandom), -11796480, -5832704);
        queue_request(ACT_SET, int'($urandom), int'($urandom), 16777215, 8388607);
        queue_request(ACT_SET, int'($urandom), int'($urandom), -16777216, -8388608);
        queue_request(ACT_SET, int'($urandom), int'($urandom), 5898240, 5832705);
        queue_request(ACT_SET, int'($urandom), int'($urandom), 5898241, -5832705);
        queue_request(ACT_SET, int'($urandom), int'($urandom), -5898240, 0);
        queue_request(ACT_SET, int'($urandom), int'($urandom), -5898241, 65536);
        queue_request(ACT_SET, int'($urandom), int'($urandom), 11796480, -65536);
        queue_request(ACT_SET, 32767, -32768, 0, 0);
        queue_request(ACT_MOVE, 0, 0, int'($urandom), int'($urandom));
        queue_request(ACT_MOVE, 32767, 32767, int'($urandom), int'($urandom));
        queue_request(ACT_MOVE, -32768, -32768, int'($urandom), int'($urandom));
        queue_request(ACT_MOVE, 1, -1, int'($urandom), int'($urandom));
        queue_request(ACT_MOVE, -1, 1, int'($urandom), int'($urandom));
        queue_request(ACT_MOVE, 8, -8, int'($urandom), int'($urandom));
        for (int k = 0; k < 3; k++)
            queue_request(ACT_MOVE, 32767, 16000, int'($urandom), int'($urandom));
        for (int k = 0; k < 3; k++)
            queue_request(ACT_MOVE, -32768, -16000, int'($urandom), int'($urandom));
        queue_request(ACT_MOVE, 0, 32767, 16777215, -8388608);
        queue_request(ACT_MOVE, 0, -32768, -16777216, 8388607);
        queue_random_requests(ITEMS_PER_PHASE);
        wait_for_views();

        // One phase per sensitivity setting, register written while idle
        for (int p = 0; p < 7; p++) begin
            write_sensitivity(sens_plan[p]);
            queue_random_requests(ITEMS_PER_PHASE);
            wait_for_views();
        end

        repeat (60) @(posedge i_clk);
        $display("covered %0d moves and %0d sets, %0d views compared field by field",
                 n_moves, n_sets, n_checked);
        $display("sensitivity written %0d times, including zero and full scale", n_settings);
        if (n_mismatch == 0 && view_expect.size() == 0) begin
            $display("yaw_pitch_view_basis test passed");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("yaw_pitch_view_basis test failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ypvb_pkg.sv
design/yaw_pitch_view_basis.sv
verif/tb_yaw_pitch_view_basis.sv
